// ----- hw/rtl/rlot_pkg.sv -----
package rlot_pkg;

  localparam int unsigned IdW   = 16;
  localparam int unsigned ZoneW = 8;
  localparam int unsigned TickW = 32;
  localparam int unsigned CntW  = 8;
  localparam int unsigned OpW   = 4;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [OpW-1:0] OP_SET_PEER   = 4'd0;
  localparam logic [OpW-1:0] OP_CLEAR_PEER = 4'd1;
  localparam logic [OpW-1:0] OP_LEARN      = 4'd2;
  localparam logic [OpW-1:0] OP_ACK        = 4'd3;
  localparam logic [OpW-1:0] OP_MISS       = 4'd4;
  localparam logic [OpW-1:0] OP_USER_RETRY = 4'd5;
  localparam logic [OpW-1:0] OP_CHECK      = 4'd6;
  localparam logic [OpW-1:0] OP_REPORT     = 4'd7;
  localparam logic [OpW-1:0] OP_NEXT_ZONE  = 4'd8;

  localparam logic [CfgAddrW-1:0] REG_LOCAL_ID       = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_BROADCAST_ID   = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_MAX_ZONE       = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_LEARN_WINDOW   = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_AUTO_START     = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_REPORT_IVL     = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_OFFLINE_LIMIT  = 3'd6;
  localparam logic [CfgAddrW-1:0] REG_OFFLINE_RETRY  = 3'd7;

  typedef struct packed {
    logic [IdW-1:0]   local_id;
    logic [IdW-1:0]   broadcast_id;
    logic [ZoneW-1:0] max_zone;
    logic [TickW-1:0] learn_window_ms;
    logic [TickW-1:0] auto_start_tick;
    logic [15:0]      report_interval_ticks;
    logic [CntW-1:0]  offline_ack_limit;
    logic [TickW-1:0] offline_retry_ticks;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [IdW-1:0]   id_value;
    logic [TickW-1:0] now_ms;
    logic [TickW-1:0] watchdog_tick;
    logic [ZoneW-1:0] zone_value;
  } evt_t;

  typedef struct packed {
    logic             learn_accepted;
    logic             peer_known;
    logic [IdW-1:0]   peer_id;
    logic [IdW-1:0]   report_target;
    logic             peer_offline;
    logic             retry_due;
    logic             report_due;
    logic [CntW-1:0]  missed_acks;
    logic [ZoneW-1:0] pair_zone;
    logic [ZoneW-1:0] zone_assigned;
  } res_t;

endpackage

// ----- hw/rtl/rlot_cfg_regs.sv -----
module rlot_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rlot_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [rlot_pkg::CfgDataW-1:0]   cfg_wdata,
  output rlot_pkg::cfg_t                  cfg_o
);

  rlot_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        rlot_pkg::REG_LOCAL_ID:      cfg_nxt.local_id = cfg_wdata[15:0];
        rlot_pkg::REG_BROADCAST_ID:  cfg_nxt.broadcast_id = cfg_wdata[15:0];
        rlot_pkg::REG_MAX_ZONE:      cfg_nxt.max_zone = cfg_wdata[7:0];
        rlot_pkg::REG_LEARN_WINDOW:  cfg_nxt.learn_window_ms = cfg_wdata;
        rlot_pkg::REG_AUTO_START:    cfg_nxt.auto_start_tick = cfg_wdata;
        rlot_pkg::REG_REPORT_IVL:    cfg_nxt.report_interval_ticks = cfg_wdata[15:0];
        rlot_pkg::REG_OFFLINE_LIMIT: cfg_nxt.offline_ack_limit = cfg_wdata[7:0];
        rlot_pkg::REG_OFFLINE_RETRY: cfg_nxt.offline_retry_ticks = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_id              <= 16'd0;
      cfg_r.broadcast_id          <= 16'hFFFF;
      cfg_r.max_zone              <= 8'd8;
      cfg_r.learn_window_ms       <= 32'd0;
      cfg_r.auto_start_tick       <= 32'd0;
      cfg_r.report_interval_ticks <= 16'd1;
      cfg_r.offline_ack_limit     <= 8'd3;
      cfg_r.offline_retry_ticks   <= 32'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ----- hw/rtl/rlot_state.sv -----
module rlot_state (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  rlot_pkg::cfg_t cfg,
  input  rlot_pkg::evt_t ev,
  output rlot_pkg::res_t res
);

  logic [15:0] peer_id_r, peer_id_nxt;
  logic        known_r, known_nxt;
  logic [7:0]  miss_r, miss_nxt;
  logic        offline_r, offline_nxt;
  logic [31:0] retry_r, retry_nxt;
  logic [31:0] last_r, last_nxt;
  logic [7:0]  pzone_r, pzone_nxt;
  logic [7:0]  azone_r, azone_nxt;

  logic        id_ok, accepted, retry_set, report_set;
  logic [7:0]  miss_inc;
  logic [31:0] retry_at_tick, neg_retry, since_retry, since_start, since_last;
  logic        old_retry_reached, retry_reached, ivl_ok, rdue;

  assign id_ok         = (ev.id_value != cfg.broadcast_id) && (ev.id_value != cfg.local_id);
  assign retry_at_tick = ev.watchdog_tick + cfg.offline_retry_ticks;
  assign neg_retry     = 32'd0 - cfg.offline_retry_ticks;
  assign since_retry   = ev.watchdog_tick - retry_r;
  assign since_start   = ev.watchdog_tick - cfg.auto_start_tick;
  assign since_last    = ev.watchdog_tick - last_r;
  assign old_retry_reached = !since_retry[31];
  assign miss_inc      = (miss_r < cfg.offline_ack_limit) ? miss_r + 8'd1 : miss_r;

  always_comb begin
    peer_id_nxt = peer_id_r;
    known_nxt   = known_r;
    miss_nxt    = miss_r;
    offline_nxt = offline_r;
    retry_nxt   = retry_r;
    last_nxt    = last_r;
    pzone_nxt   = pzone_r;
    azone_nxt   = azone_r;
    accepted    = 1'b0;
    retry_set   = 1'b0;
    report_set  = 1'b0;
    case (ev.op)
      rlot_pkg::OP_SET_PEER: begin
        peer_id_nxt = ev.id_value;
        known_nxt   = id_ok;
      end
      rlot_pkg::OP_CLEAR_PEER: begin
        peer_id_nxt = cfg.broadcast_id;
        known_nxt   = 1'b0;
      end
      rlot_pkg::OP_LEARN: begin
        if (!known_r && (ev.now_ms < cfg.learn_window_ms) && id_ok) begin
          peer_id_nxt = ev.id_value;
          known_nxt   = 1'b1;
          accepted    = 1'b1;
        end
      end
      rlot_pkg::OP_ACK: begin
        miss_nxt    = 8'd0;
        offline_nxt = 1'b0;
        if ((ev.zone_value != 8'd0) && (ev.zone_value <= cfg.max_zone)) begin
          azone_nxt = ev.zone_value;
          pzone_nxt = ev.zone_value;
        end
      end
      rlot_pkg::OP_MISS: begin
        miss_nxt = miss_inc;
        if (miss_inc >= cfg.offline_ack_limit) begin
          offline_nxt = 1'b1;
          retry_nxt   = retry_at_tick;
          retry_set   = 1'b1;
        end
      end
      rlot_pkg::OP_USER_RETRY: begin
        miss_nxt    = 8'd0;
        offline_nxt = 1'b0;
      end
      rlot_pkg::OP_REPORT: begin
        if (offline_r && old_retry_reached) begin
          retry_nxt = retry_at_tick;
          retry_set = 1'b1;
        end
        last_nxt   = ev.watchdog_tick;
        report_set = 1'b1;
      end
      rlot_pkg::OP_NEXT_ZONE: begin
        if ((pzone_r == 8'd0) || (pzone_r >= cfg.max_zone)) begin
          pzone_nxt = 8'd1;
        end else begin
          pzone_nxt = pzone_r + 8'd1;
        end
      end
      default: ;
    endcase
  end

  // a freshly scheduled retry sits offline_retry_ticks ahead of this tick
  assign retry_reached = retry_set ? !neg_retry[31] : old_retry_reached;
  assign rdue          = offline_nxt && retry_reached;
  assign ivl_ok        = report_set ? (cfg.report_interval_ticks == 16'd0)
                                    : (since_last >= {16'd0, cfg.report_interval_ticks});

  always_comb begin
    res.learn_accepted = accepted;
    res.peer_known     = known_nxt;
    res.peer_id        = peer_id_nxt;
    res.report_target  = known_nxt ? peer_id_nxt : cfg.broadcast_id;
    res.peer_offline   = offline_nxt;
    res.retry_due      = rdue;
    res.report_due     = (!offline_nxt || rdue) && !since_start[31] && ivl_ok;
    res.missed_acks    = miss_nxt;
    res.pair_zone      = pzone_nxt;
    res.zone_assigned  = azone_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_id_r <= 16'hFFFF;
      known_r   <= 1'b0;
      miss_r    <= 8'd0;
      offline_r <= 1'b0;
      retry_r   <= 32'd0;
      last_r    <= 32'd0;
      pzone_r   <= 8'd0;
      azone_r   <= 8'd0;
    end else if (en) begin
      peer_id_r <= peer_id_nxt;
      known_r   <= known_nxt;
      miss_r    <= miss_nxt;
      offline_r <= offline_nxt;
      retry_r   <= retry_nxt;
      last_r    <= last_nxt;
      pzone_r   <= pzone_nxt;
      azone_r   <= azone_nxt;
    end
  end

endmodule

// ----- hw/rtl/radio_link_offline_tracker.sv -----
// Radio link offline tracker, slave side.
// Input channel (in_*): one event per transfer, op plus id, time, tick and
// zone. Result channel (out_*): one full link status per event, in order.
// Configuration (cfg_*): write enable, register index and data; write only
// while no event is in flight.
// An accepted event is held in the input register; its status is computed
// and loaded into the result register when that register is free or drained.
// Throughput: one event per cycle while out_ready is high, set by the single
// state update stage between the input register and the result register.
// Reset (rst_n low at a clock edge) returns configuration and link state to
// their defaults and empties both register stages.
// When the receiver stalls the result register holds its status; one more
// event is taken into the input register, then in_ready falls until the
// result is transferred.
module radio_link_offline_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rlot_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [rlot_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    in_op,
  input  logic [15:0]                   in_id_value,
  input  logic [31:0]                   in_now_ms,
  input  logic [31:0]                   in_watchdog_tick,
  input  logic [7:0]                    in_zone_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_learn_accepted,
  output logic                          out_peer_known,
  output logic [15:0]                   out_peer_id,
  output logic [15:0]                   out_report_target,
  output logic                          out_peer_offline,
  output logic                          out_retry_due,
  output logic                          out_report_due,
  output logic [7:0]                    out_missed_acks,
  output logic [7:0]                    out_pair_zone,
  output logic [7:0]                    out_zone_assigned
);

  rlot_pkg::cfg_t cfg;
  rlot_pkg::evt_t ev_r, ev_nxt;
  rlot_pkg::res_t res, res_r;
  logic           ev_vld_r, out_vld_r, advance, take;

  rlot_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  assign advance  = ev_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !ev_vld_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    ev_nxt.op            = in_op;
    ev_nxt.id_value      = in_id_value;
    ev_nxt.now_ms        = in_now_ms;
    ev_nxt.watchdog_tick = in_watchdog_tick;
    ev_nxt.zone_value    = in_zone_value;
  end

  rlot_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .cfg   (cfg),
    .ev    (ev_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (take) begin
        ev_vld_r <= 1'b1;
      end else if (advance) begin
        ev_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev_r <= ev_nxt;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_learn_accepted = res_r.learn_accepted;
  assign out_peer_known     = res_r.peer_known;
  assign out_peer_id        = res_r.peer_id;
  assign out_report_target  = res_r.report_target;
  assign out_peer_offline   = res_r.peer_offline;
  assign out_retry_due      = res_r.retry_due;
  assign out_report_due     = res_r.report_due;
  assign out_missed_acks    = res_r.missed_acks;
  assign out_pair_zone      = res_r.pair_zone;
  assign out_zone_assigned  = res_r.zone_assigned;

endmodule

// ----- hw/rtl/rlot_checker.sv -----
module rlot_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_learn_accepted,
  input logic        out_peer_known,
  input logic        out_peer_offline,
  input logic        out_retry_due,
  input logic [15:0] out_peer_id
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_peer_id))
    else $error("result dropped or changed under stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_retry_offline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_retry_due |-> out_peer_offline)
    else $error("retry due while peer online");

  a_learn_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_learn_accepted |-> out_peer_known)
    else $error("learn accepted but peer not known");

endmodule

bind radio_link_offline_tracker rlot_checker u_rlot_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_learn_accepted (out_learn_accepted),
  .out_peer_known     (out_peer_known),
  .out_peer_offline   (out_peer_offline),
  .out_retry_due      (out_retry_due),
  .out_peer_id        (out_peer_id)
);

// ----- dv/tb.sv -----
module tb;
  import rlot_pkg::*;

  localparam logic [OpW-1:0] OP_UNUSED_FIRST = OP_NEXT_ZONE + 4'd1;
  localparam logic [OpW-1:0] OP_CODE_MAX     = '1;

  typedef enum {CFG_TYPICAL, CFG_HIGHEST, CFG_LOWEST} cfg_style_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [3:0]          in_op;
  logic [15:0]         in_id_value;
  logic [31:0]         in_now_ms;
  logic [31:0]         in_watchdog_tick;
  logic [7:0]          in_zone_value;
  logic                out_valid;
  logic                out_ready;
  logic                out_learn_accepted;
  logic                out_peer_known;
  logic [15:0]         out_peer_id;
  logic [15:0]         out_report_target;
  logic                out_peer_offline;
  logic                out_retry_due;
  logic                out_report_due;
  logic [7:0]          out_missed_acks;
  logic [7:0]          out_pair_zone;
  logic [7:0]          out_zone_assigned;

  // predicted link state and configuration
  cfg_t        link_cfg;
  logic [15:0] link_peer_id;
  logic        link_peer_known;
  logic [7:0]  link_misses;
  logic        link_offline;
  logic [31:0] link_retry_tick;
  logic [31:0] link_report_tick;
  logic [7:0]  link_pair_zone;
  logic [7:0]  link_zone_given;

  res_t        pending_status_q[$];
  logic        idling_on = 1'b1;
  logic [31:0] tick_cursor;
  int          mismatch_count;
  int          results_checked;
  int          events_sent;
  int          reg_writes;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  radio_link_offline_tracker u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_id_value       (in_id_value),
    .in_now_ms         (in_now_ms),
    .in_watchdog_tick  (in_watchdog_tick),
    .in_zone_value     (in_zone_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_learn_accepted(out_learn_accepted),
    .out_peer_known    (out_peer_known),
    .out_peer_id       (out_peer_id),
    .out_report_target (out_report_target),
    .out_peer_offline  (out_peer_offline),
    .out_retry_due     (out_retry_due),
    .out_report_due    (out_report_due),
    .out_missed_acks   (out_missed_acks),
    .out_pair_zone     (out_pair_zone),
    .out_zone_assigned (out_zone_assigned)
  );

  function automatic logic tick_at_or_after(logic [31:0] now, logic [31:0] mark);
    logic [31:0] diff;
    diff = now - mark;
    return !diff[31];
  endfunction

  function automatic logic retry_pending(logic [31:0] tick);
    return link_offline && tick_at_or_after(tick, link_retry_tick);
  endfunction

  function automatic void adopt_peer(logic [15:0] id);
    link_peer_id    = id;
    link_peer_known = (id != link_cfg.broadcast_id) && (id != link_cfg.local_id);
  endfunction

  function automatic res_t advance_link_state(evt_t ev);
    res_t        st;
    logic        learned;
    logic        rdue;
    logic [31:0] since_report;
    learned = 1'b0;
    case (ev.op)
      OP_SET_PEER: adopt_peer(ev.id_value);
      OP_CLEAR_PEER: begin
        link_peer_known = 1'b0;
        link_peer_id    = link_cfg.broadcast_id;
      end
      OP_LEARN: begin
        if (!link_peer_known && ev.now_ms < link_cfg.learn_window_ms &&
            ev.id_value != link_cfg.broadcast_id && ev.id_value != link_cfg.local_id) begin
          adopt_peer(ev.id_value);
          learned = 1'b1;
        end
      end
      OP_ACK: begin
        link_misses  = '0;
        link_offline = 1'b0;
        if (ev.zone_value >= 8'd1 && ev.zone_value <= link_cfg.max_zone) begin
          link_zone_given = ev.zone_value;
          link_pair_zone  = ev.zone_value;
        end
      end
      OP_MISS: begin
        if (link_misses < link_cfg.offline_ack_limit) link_misses = link_misses + 8'd1;
        if (link_misses >= link_cfg.offline_ack_limit) begin
          link_offline    = 1'b1;
          link_retry_tick = ev.watchdog_tick + link_cfg.offline_retry_ticks;
        end
      end
      OP_USER_RETRY: begin
        link_misses  = '0;
        link_offline = 1'b0;
      end
      OP_REPORT: begin
        if (retry_pending(ev.watchdog_tick))
          link_retry_tick = ev.watchdog_tick + link_cfg.offline_retry_ticks;
        link_report_tick = ev.watchdog_tick;
      end
      OP_NEXT_ZONE: begin
        if (link_pair_zone == 8'd0 || link_pair_zone >= link_cfg.max_zone) link_pair_zone = 8'd1;
        else link_pair_zone = link_pair_zone + 8'd1;
      end
      default: ;
    endcase
    rdue         = retry_pending(ev.watchdog_tick);
    since_report = ev.watchdog_tick - link_report_tick;
    st.learn_accepted = learned;
    st.peer_known     = link_peer_known;
    st.peer_id        = link_peer_id;
    st.report_target  = link_peer_known ? link_peer_id : link_cfg.broadcast_id;
    st.peer_offline   = link_offline;
    st.retry_due      = rdue;
    st.report_due     = (!link_offline || rdue) &&
                        tick_at_or_after(ev.watchdog_tick, link_cfg.auto_start_tick) &&
                        since_report >= {16'h0, link_cfg.report_interval_ticks};
    st.missed_acks    = link_misses;
    st.pair_zone      = link_pair_zone;
    st.zone_assigned  = link_zone_given;
    return st;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : status_checker
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status_q.size() == 0) begin
        report_mismatch("status transfer with nothing outstanding");
      end else begin
        want = pending_status_q.pop_front();
        check_field("learn_accepted", 32'(out_learn_accepted), 32'(want.learn_accepted));
        check_field("peer_known", 32'(out_peer_known), 32'(want.peer_known));
        check_field("peer_id", 32'(out_peer_id), 32'(want.peer_id));
        check_field("report_target", 32'(out_report_target), 32'(want.report_target));
        check_field("peer_offline", 32'(out_peer_offline), 32'(want.peer_offline));
        check_field("retry_due", 32'(out_retry_due), 32'(want.retry_due));
        check_field("report_due", 32'(out_report_due), 32'(want.report_due));
        check_field("missed_acks", 32'(out_missed_acks), 32'(want.missed_acks));
        check_field("pair_zone", 32'(out_pair_zone), 32'(want.pair_zone));
        check_field("zone_assigned", 32'(out_zone_assigned), 32'(want.zone_assigned));
        results_checked++;
      end
    end
  end

  // receiver back-pressure in bursts
  initial begin : result_sink
    int stall;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_link_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_LOCAL_ID:      link_cfg.local_id              = value[15:0];
      REG_BROADCAST_ID:  link_cfg.broadcast_id          = value[15:0];
      REG_MAX_ZONE:      link_cfg.max_zone              = value[7:0];
      REG_LEARN_WINDOW:  link_cfg.learn_window_ms       = value;
      REG_AUTO_START:    link_cfg.auto_start_tick       = value;
      REG_REPORT_IVL:    link_cfg.report_interval_ticks = value[15:0];
      REG_OFFLINE_LIMIT: link_cfg.offline_ack_limit     = value[7:0];
      REG_OFFLINE_RETRY: link_cfg.offline_retry_ticks   = value;
      default: ;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // valid is left high after the transfer; the caller replaces or drops it
  task automatic send_event(input logic [3:0] op, input logic [15:0] id, input logic [31:0] now,
                            input logic [31:0] tick, input logic [7:0] zone);
    evt_t ev;
    ev.op            = op;
    ev.id_value      = id;
    ev.now_ms        = now;
    ev.watchdog_tick = tick;
    ev.zone_value    = zone;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_id_value      <= id;
    in_now_ms        <= now;
    in_watchdog_tick <= tick;
    in_zone_value    <= zone;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_status_q.push_back(advance_link_state(ev));
    events_sent++;
  endtask

  task automatic test_reset_state();
    send_event(OP_CHECK, 16'h0000, 32'h0, 32'h0, 8'h00);
    send_event(OP_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_peer_learning();
    write_link_reg(REG_LOCAL_ID, 32'h1234);
    write_link_reg(REG_LEARN_WINDOW, 32'd1000);
    send_event(OP_LEARN, 16'h5555, 32'd1000, 32'd10, 8'd0);
    send_event(OP_LEARN, 16'hFFFF, 32'd10, 32'd11, 8'd0);
    send_event(OP_LEARN, 16'h1234, 32'd10, 32'd12, 8'd0);
    send_event(OP_LEARN, 16'h5555, 32'd999, 32'd13, 8'd0);
    send_event(OP_LEARN, 16'h6666, 32'd0, 32'd14, 8'd0);
    send_event(OP_CLEAR_PEER, 16'h0000, 32'd0, 32'd15, 8'd0);
    send_event(OP_SET_PEER, 16'h1234, 32'd0, 32'd16, 8'd0);
    send_event(OP_SET_PEER, 16'h0000, 32'd0, 32'd17, 8'd0);
    send_event(OP_SET_PEER, 16'hFFFF, 32'd0, 32'd18, 8'd0);
  endtask

  task automatic test_ack_miss_retry();
    write_link_reg(REG_OFFLINE_RETRY, 32'd10);
    send_event(OP_MISS, 16'h0, 32'd0, 32'd100, 8'd0);
    send_event(OP_MISS, 16'h0, 32'd0, 32'd101, 8'd0);
    send_event(OP_MISS, 16'h0, 32'd0, 32'd102, 8'd0);
    send_event(OP_MISS, 16'h0, 32'd0, 32'd103, 8'd0);
    send_event(OP_CHECK, 16'h0, 32'd0, 32'd113, 8'd0);
    send_event(OP_REPORT, 16'h0, 32'd0, 32'd113, 8'd0);
    send_event(OP_ACK, 16'h0, 32'd0, 32'd114, 8'd0);
    send_event(OP_MISS, 16'h0, 32'd0, 32'd115, 8'd0);
    send_event(OP_USER_RETRY, 16'h0, 32'd0, 32'd116, 8'd0);
    send_event(OP_ACK, 16'h0, 32'd0, 32'd117, 8'hFF);
    send_event(OP_ACK, 16'h0, 32'd0, 32'd118, 8'd8);
  endtask

  task automatic test_zone_wrap();
    send_event(OP_NEXT_ZONE, 16'h0, 32'd0, 32'd119, 8'd0);
    send_event(OP_NEXT_ZONE, 16'h0, 32'd0, 32'd120, 8'd0);
  endtask

  task automatic test_zero_limits();
    write_link_reg(REG_OFFLINE_LIMIT, 32'd0);
    write_link_reg(REG_MAX_ZONE, 32'd0);
    send_event(OP_MISS, 16'h0, 32'd0, 32'd121, 8'd0);
    send_event(OP_NEXT_ZONE, 16'h0, 32'd0, 32'd122, 8'd0);
  endtask

  task automatic test_unused_ops();
    send_event(OP_UNUSED_FIRST, 16'hA5A5, 32'd0, 32'd123, 8'd3);
    send_event(OP_CODE_MAX, 16'h5A5A, 32'hFFFF_FFFF, 32'd124, 8'd4);
  endtask

  task automatic test_random_traffic(input cfg_style_t style, input int count,
                                     input bit with_idling);
    logic [3:0]  op;
    logic [15:0] id;
    logic [31:0] now;
    logic [31:0] tick;
    logic [7:0]  zone;
    int          pick;
    idling_on = with_idling;
    case (style)
      CFG_HIGHEST: begin
        write_link_reg(REG_LOCAL_ID, 32'hFFFF);
        write_link_reg(REG_BROADCAST_ID, 32'h0);
        write_link_reg(REG_MAX_ZONE, 32'd255);
        write_link_reg(REG_LEARN_WINDOW, 32'hFFFF_FFFF);
        write_link_reg(REG_AUTO_START, 32'hFFFF_FFFF);
        write_link_reg(REG_REPORT_IVL, 32'hFFFF);
        write_link_reg(REG_OFFLINE_LIMIT, 32'd255);
        write_link_reg(REG_OFFLINE_RETRY, 32'hFFFF_FFFF);
      end
      CFG_LOWEST: begin
        write_link_reg(REG_LOCAL_ID, 32'h0);
        write_link_reg(REG_BROADCAST_ID, 32'h0);
        write_link_reg(REG_MAX_ZONE, 32'd1);
        write_link_reg(REG_LEARN_WINDOW, 32'd0);
        write_link_reg(REG_AUTO_START, 32'd0);
        write_link_reg(REG_REPORT_IVL, 32'd0);
        write_link_reg(REG_OFFLINE_LIMIT, 32'd1);
        write_link_reg(REG_OFFLINE_RETRY, 32'd0);
      end
      default: begin
        write_link_reg(REG_LOCAL_ID, 32'($urandom_range(0, 65535)));
        write_link_reg(REG_BROADCAST_ID,
                       $urandom_range(0, 1) ? 32'hFFFF : 32'($urandom_range(0, 65535)));
        write_link_reg(REG_MAX_ZONE, 32'($urandom_range(1, 12)));
        write_link_reg(REG_LEARN_WINDOW, $urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom()));
        write_link_reg(REG_AUTO_START, tick_cursor + 32'($urandom_range(0, 60)) - 32'd30);
        write_link_reg(REG_REPORT_IVL, 32'($urandom_range(0, 8)));
        write_link_reg(REG_OFFLINE_LIMIT, 32'($urandom_range(1, 5)));
        write_link_reg(REG_OFFLINE_RETRY, 32'($urandom_range(0, 20)));
      end
    endcase
    for (int i = 0; i < count; i++) begin
      if (with_idling && $urandom_range(0, 39) == 0) idling_on = !idling_on;
      if (with_idling && $urandom_range(0, 79) == 0) settle();

      pick = $urandom_range(0, 99);
      if (pick < 8) op = OP_SET_PEER;
      else if (pick < 13) op = OP_CLEAR_PEER;
      else if (pick < 23) op = OP_LEARN;
      else if (pick < 35) op = OP_ACK;
      else if (pick < 55) op = OP_MISS;
      else if (pick < 60) op = OP_USER_RETRY;
      else if (pick < 72) op = OP_CHECK;
      else if (pick < 84) op = OP_REPORT;
      else if (pick < 95) op = OP_NEXT_ZONE;
      else op = 4'($urandom_range(OP_UNUSED_FIRST, OP_CODE_MAX));

      case ($urandom_range(0, 9))
        4: id = link_cfg.broadcast_id;
        5: id = link_cfg.local_id;
        6: id = link_peer_id;
        7: id = 16'h0000;
        8: id = 16'hFFFF;
        default: id = 16'($urandom_range(0, 65535));
      endcase

      if ($urandom_range(0, 1) == 0)
        now = link_cfg.learn_window_ms + 32'($urandom_range(0, 6)) - 32'd3;
      else
        now = $urandom();

      // ticks mostly creep forward, with jumps, wraps and the odd step back
      pick = $urandom_range(0, 99);
      if (pick < 75) tick_cursor = tick_cursor + 32'($urandom_range(0, 3));
      else if (pick < 90) tick_cursor = tick_cursor + 32'($urandom_range(0, 40000));
      else if (pick < 95) tick_cursor = $urandom();
      tick = (pick >= 95) ? tick_cursor - 32'($urandom_range(1, 20)) : tick_cursor;

      if ($urandom_range(0, 9) < 7)
        zone = 8'($urandom_range(0, 32'(link_cfg.max_zone) + 1));
      else
        zone = 8'($urandom_range(0, 255));

      send_event(op, id, now, tick, zone);
    end
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_addr         <= '0;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_op            <= '0;
    in_id_value      <= '0;
    in_now_ms        <= '0;
    in_watchdog_tick <= '0;
    in_zone_value    <= '0;

    link_cfg.local_id              = 16'h0;
    link_cfg.broadcast_id          = 16'hFFFF;
    link_cfg.max_zone              = 8'd8;
    link_cfg.learn_window_ms       = 32'd0;
    link_cfg.auto_start_tick       = 32'd0;
    link_cfg.report_interval_ticks = 16'd1;
    link_cfg.offline_ack_limit     = 8'd3;
    link_cfg.offline_retry_ticks   = 32'd1;
    link_peer_id     = 16'hFFFF;
    link_peer_known  = 1'b0;
    link_misses      = '0;
    link_offline     = 1'b0;
    link_retry_tick  = '0;
    link_report_tick = '0;
    link_pair_zone   = '0;
    link_zone_given  = '0;
    tick_cursor      = 32'd200;
    mismatch_count   = 0;
    results_checked  = 0;
    events_sent      = 0;
    reg_writes       = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_peer_learning();
    test_ack_miss_retry();
    test_zone_wrap();
    test_zero_limits();
    test_unused_ops();
    test_random_traffic(CFG_TYPICAL, 250, 1'b1);
    test_random_traffic(CFG_HIGHEST, 150, 1'b1);
    test_random_traffic(CFG_LOWEST, 150, 1'b1);
    test_random_traffic(CFG_TYPICAL, 250, 1'b1);
    test_random_traffic(CFG_TYPICAL, 120, 1'b0);
    settle();

    $display("Ran %0d link events (directed, then random with typical and extreme settings)",
             events_sent);
    $display("over %0d register writes; %0d status transfers checked, %0d mismatches.",
             reg_writes, results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_status_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : run_limit
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
